// File: rtl/core/cdp_pkg.sv
// Package with the payload types, phase encoding and constants of the directory parser.
`default_nettype none

package cdp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [31:0] byte_index;
    logic [31:0] entry_number;
    logic [31:0] resource_type;
    logic [31:0] size_out;
    logic [31:0] rel_offset;
    logic [31:0] size_in;
    logic        encrypted;
    logic [31:0] name_length;
    logic [31:0] position;
    logic        key_present;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_TAG,
    PH_KIND,
    PH_LEN,
    PH_DATA,
    PH_COUNT,
    PH_NAMELEN,
    PH_NAME,
    PH_FIELDS,
    PH_PENDING,
    PH_DONE
  } phase_t;

  localparam logic [2:0] KIND_KEY        = 3'd0;
  localparam logic [2:0] KIND_NAME       = 3'd1;
  localparam logic [2:0] KIND_RECORD     = 3'd2;
  localparam logic [2:0] KIND_DIR_END    = 3'd3;
  localparam logic [2:0] KIND_BAD_MAGIC  = 3'd4;
  localparam logic [2:0] KIND_HEADER_END = 3'd5;

  localparam logic [31:0] TAG_MAGIC = 32'h4B464E42;
  localparam logic [31:0] TAG_KEY   = 32'h464C4944;
  localparam logic [31:0] TAG_END   = 32'h454E4448;
  localparam logic [31:0] KEY_LEN   = 32'd16;
  localparam logic [7:0]  FIELD_KIND_DATA = 8'd2;
  localparam logic [31:0] RECORD_WORDS    = 32'd4;

endpackage

`default_nettype wire

// File: rtl/core/cdp_stream_if.sv
// Valid/ready stream interface that carries one payload per transaction.
`default_nettype none

interface cdp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/container_directory_parser_unit.sv
// Archive header and directory parser with one output register.
// The archive channel takes one file byte per transaction, with file_start set on
// the first byte of a file to restart the parse. The report channel carries key
// bytes, name bytes, entry records, the directory end, header end and bad magic
// results; at most one result comes from each byte.
// A result is presented in the cycle after the byte that causes it is accepted.
// One byte is accepted every cycle while no result is stalled; the parse state is
// updated by short logic between the state registers and the output register.
// The directory end that follows the last entry record is reported with the next
// byte after the directory, carrying the position where the directory ends.
// Reset clears the parse state to the magic check and empties the output
// register. When the receiver stalls with a result waiting, archive.ready drops
// until that result is taken; with the output register empty or draining, a new
// byte is taken in the same cycle.
// Bytes after the directory end result, or after a bad magic, produce no results
// until the next file_start.
`default_nettype none

module container_directory_parser_unit
  import cdp_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  cdp_stream_if.sink   archive,
  cdp_stream_if.source report
);

  phase_t      phase, phase_next;
  logic [1:0]  sub_count, sub_count_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic        data_field, data_field_next;
  logic [31:0] word_shift, word_shift_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic        capture_key, capture_key_next;
  logic        key_seen, key_seen_next;
  logic [31:0] entries_total, entries_total_next;
  logic [31:0] entry_index, entry_index_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] entry_words [4];

  logic        out_valid;
  out_item_t   out_data;
  out_item_t   res;
  logic        emit;
  logic        word_we;
  logic [1:0]  word_sel;
  logic        accept;

  assign archive.ready = !out_valid || report.ready;
  assign accept        = archive.valid && archive.ready;
  assign report.valid  = out_valid;
  assign report.data   = out_data;

  always_comb begin
    phase_t      cur_phase;
    logic [1:0]  cur_sub;
    logic [31:0] cur_tag;
    logic        cur_data_field;
    logic [31:0] cur_word;
    logic [31:0] cur_left;
    logic        cur_capture;
    logic        cur_key_seen;
    logic [31:0] cur_total;
    logic [31:0] cur_index;
    logic [31:0] cur_pos;
    logic [7:0]  b;
    logic        sub_full;
    logic [31:0] tag_shifted;
    logic [31:0] word_shifted;
    logic [31:0] left_dec;
    logic [31:0] index_inc;
    logic        field_done;

    b = archive.data.data_byte;
    if (archive.data.file_start) begin
      cur_phase      = PH_MAGIC;
      cur_sub        = '0;
      cur_tag        = '0;
      cur_data_field = 1'b0;
      cur_word       = '0;
      cur_left       = '0;
      cur_capture    = 1'b0;
      cur_key_seen   = 1'b0;
      cur_total      = '0;
      cur_index      = '0;
      cur_pos        = '0;
    end else begin
      cur_phase      = phase;
      cur_sub        = sub_count;
      cur_tag        = tag_shift;
      cur_data_field = data_field;
      cur_word       = word_shift;
      cur_left       = bytes_left;
      cur_capture    = capture_key;
      cur_key_seen   = key_seen;
      cur_total      = entries_total;
      cur_index      = entry_index;
      cur_pos        = byte_position;
    end

    sub_full     = (cur_sub == 2'd3);
    tag_shifted  = {cur_tag[23:0], b};
    word_shifted = {b, cur_word[31:8]};
    left_dec     = cur_left - 32'd1;
    index_inc    = cur_index + 32'd1;
    field_done   = 1'b0;

    phase_next         = cur_phase;
    sub_count_next     = cur_sub;
    tag_shift_next     = cur_tag;
    data_field_next    = cur_data_field;
    word_shift_next    = cur_word;
    bytes_left_next    = cur_left;
    capture_key_next   = cur_capture;
    key_seen_next      = cur_key_seen;
    entries_total_next = cur_total;
    entry_index_next   = cur_index;
    byte_position_next = cur_pos + 32'd1;

    emit     = 1'b0;
    res      = '0;
    word_we  = 1'b0;
    word_sel = cur_left[1:0];

    case (cur_phase)
      PH_MAGIC: begin
        tag_shift_next = tag_shifted;
        sub_count_next = cur_sub + 2'd1;
        if (sub_full) begin
          if (tag_shifted != TAG_MAGIC) begin
            phase_next = PH_DONE;
            emit       = 1'b1;
            res.kind   = KIND_BAD_MAGIC;
          end else begin
            phase_next = PH_TAG;
          end
        end
      end
      PH_TAG: begin
        tag_shift_next = tag_shifted;
        sub_count_next = cur_sub + 2'd1;
        if (sub_full) begin
          phase_next = PH_KIND;
        end
      end
      PH_KIND: begin
        data_field_next = (b == FIELD_KIND_DATA);
        phase_next      = PH_LEN;
      end
      PH_LEN: begin
        word_shift_next = word_shifted;
        sub_count_next  = cur_sub + 2'd1;
        if (sub_full) begin
          if (cur_data_field && word_shifted != 32'd0) begin
            bytes_left_next  = word_shifted;
            capture_key_next = (cur_tag == TAG_KEY) && (word_shifted == KEY_LEN);
            phase_next       = PH_DATA;
          end else begin
            field_done = 1'b1;
          end
        end
      end
      PH_DATA: begin
        bytes_left_next = left_dec;
        if (cur_capture) begin
          emit            = 1'b1;
          res.kind        = KIND_KEY;
          res.byte_value  = b;
          res.byte_index  = KEY_LEN - cur_left;
          res.key_present = cur_key_seen || (left_dec == 32'd0);
          if (left_dec == 32'd0) begin
            key_seen_next    = 1'b1;
            capture_key_next = 1'b0;
            phase_next       = PH_TAG;
          end
        end else if (left_dec == 32'd0) begin
          field_done = 1'b1;
        end
      end
      PH_COUNT: begin
        word_shift_next = word_shifted;
        sub_count_next  = cur_sub + 2'd1;
        if (sub_full) begin
          entries_total_next = word_shifted;
          entry_index_next   = '0;
          if (word_shifted == 32'd0) begin
            phase_next      = PH_DONE;
            emit            = 1'b1;
            res.kind        = KIND_DIR_END;
            res.position    = byte_position_next;
            res.key_present = cur_key_seen;
          end else begin
            phase_next = PH_NAMELEN;
          end
        end
      end
      PH_NAMELEN: begin
        word_shift_next = word_shifted;
        sub_count_next  = cur_sub + 2'd1;
        if (sub_full) begin
          tag_shift_next  = word_shifted;
          bytes_left_next = word_shifted;
          phase_next      = (word_shifted == 32'd0) ? PH_FIELDS : PH_NAME;
        end
      end
      PH_NAME: begin
        emit             = 1'b1;
        res.kind         = KIND_NAME;
        res.byte_value   = b;
        res.byte_index   = cur_tag - cur_left;
        res.entry_number = cur_index;
        res.key_present  = cur_key_seen;
        bytes_left_next  = left_dec;
        if (left_dec == 32'd0) begin
          phase_next = PH_FIELDS;
        end
      end
      PH_FIELDS: begin
        word_shift_next = word_shifted;
        sub_count_next  = cur_sub + 2'd1;
        if (sub_full) begin
          if (cur_left == RECORD_WORDS) begin
            bytes_left_next   = '0;
            emit              = 1'b1;
            res.kind          = KIND_RECORD;
            res.entry_number  = cur_index;
            res.resource_type = entry_words[0];
            res.size_out      = entry_words[1];
            res.rel_offset    = entry_words[2];
            res.size_in       = entry_words[3];
            res.encrypted     = word_shifted[0];
            res.name_length   = cur_tag;
            res.key_present   = cur_key_seen;
            entry_index_next  = index_inc;
            phase_next        = (index_inc == cur_total) ? PH_PENDING : PH_NAMELEN;
          end else begin
            word_we         = 1'b1;
            bytes_left_next = cur_left + 32'd1;
          end
        end
      end
      PH_PENDING: begin
        phase_next       = PH_DONE;
        emit             = 1'b1;
        res.kind         = KIND_DIR_END;
        res.entry_number = cur_total;
        res.position     = cur_pos;
        res.key_present  = cur_key_seen;
      end
      default: begin
      end
    endcase

    if (field_done) begin
      if (cur_tag == TAG_END) begin
        phase_next      = PH_COUNT;
        emit            = 1'b1;
        res.kind        = KIND_HEADER_END;
        res.key_present = cur_key_seen;
      end else begin
        phase_next = PH_TAG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_MAGIC;
      sub_count     <= '0;
      tag_shift     <= '0;
      data_field    <= 1'b0;
      word_shift    <= '0;
      bytes_left    <= '0;
      capture_key   <= 1'b0;
      key_seen      <= 1'b0;
      entries_total <= '0;
      entry_index   <= '0;
      byte_position <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        sub_count     <= sub_count_next;
        tag_shift     <= tag_shift_next;
        data_field    <= data_field_next;
        word_shift    <= word_shift_next;
        bytes_left    <= bytes_left_next;
        capture_key   <= capture_key_next;
        key_seen      <= key_seen_next;
        entries_total <= entries_total_next;
        entry_index   <= entry_index_next;
        byte_position <= byte_position_next;
        out_valid     <= emit;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data <= res;
    end
    if (accept && word_we) begin
      entry_words[word_sel] <= word_shift_next;
    end
  end

`ifndef ASSERT_OFF
  a_done_is_silent: assert property (@(posedge clk) disable iff (rst)
    accept && !archive.data.file_start && phase == PH_DONE |=> !out_valid)
    else $error("result produced after the directory was closed");

  a_key_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_KEY |-> out_data.byte_index < KEY_LEN)
    else $error("key byte index out of range");

  a_bad_magic_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_BAD_MAGIC |-> !out_data.key_present)
    else $error("bad magic result carries a key flag");

  a_sub_count_phase: assert property (@(posedge clk) disable iff (rst)
    sub_count != 2'd0 |-> phase == PH_MAGIC || phase == PH_TAG || phase == PH_LEN ||
                          phase == PH_COUNT || phase == PH_NAMELEN || phase == PH_FIELDS)
    else $error("partial word count outside a word phase");
`endif

endmodule

`default_nettype wire

// File: bench/tb_container_directory_parser_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for the archive directory parser: directed and random archive streams.
module tb_container_directory_parser_unit
  import cdp_pkg::*;
();

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_BYTES = 600;

  logic clk;
  logic rst;

  cdp_stream_if #(.payload_t(in_item_t)) archive_if ();
  cdp_stream_if #(.payload_t(out_item_t)) report_if ();

  container_directory_parser_unit uut (
    .clk(clk),
    .rst(rst),
    .archive(archive_if),
    .report(report_if)
  );

  phase_t      ps_phase;
  logic [3:0]  ps_count;
  logic [31:0] ps_tag;
  logic [7:0]  ps_kind;
  logic [31:0] ps_word;
  logic [31:0] ps_left;
  logic        ps_capture;
  logic        ps_key_seen;
  logic [31:0] ps_entries;
  logic [31:0] ps_entry_idx;
  logic [31:0] ps_fields [5];
  logic [31:0] ps_pos;

  out_item_t  directory_reports [$];
  logic [7:0] file_bytes [$];
  int error_count = 0;
  int bytes_sent = 0;
  int source_idle_pct = 27;
  int sink_stall_pct = 27;
  int quiet_cycles = 0;

  function automatic void clear_parse_state();
    ps_phase = PH_MAGIC;
    ps_count = '0;
    ps_tag = '0;
    ps_kind = '0;
    ps_word = '0;
    ps_left = '0;
    ps_capture = 1'b0;
    ps_key_seen = 1'b0;
    ps_entries = '0;
    ps_entry_idx = '0;
    for (int i = 0; i < 5; i++) ps_fields[i] = '0;
    ps_pos = '0;
  endfunction

  function automatic bit word_byte_done(input logic [7:0] b);
    ps_word = {b, ps_word[31:8]};
    ps_count = ps_count + 4'd1;
    if (ps_count >= 4'd4) begin
      ps_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit tag_byte_done(input logic [7:0] b);
    ps_tag = {ps_tag[23:0], b};
    ps_count = ps_count + 4'd1;
    if (ps_count >= 4'd4) begin
      ps_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit field_done(output out_item_t res);
    res = '0;
    if (ps_tag == TAG_END) begin
      ps_phase = PH_COUNT;
      res.kind = KIND_HEADER_END;
      res.key_present = ps_key_seen;
      return 1'b1;
    end
    ps_phase = PH_TAG;
    return 1'b0;
  endfunction

  function automatic bit parse_byte(input in_item_t item, output out_item_t res);
    logic [7:0]  b;
    logic [31:0] prev_pos;
    logic [31:0] idx;
    logic        cap;
    b = item.data_byte;
    res = '0;
    if (item.file_start) clear_parse_state();
    prev_pos = ps_pos;
    ps_pos = ps_pos + 32'd1;
    case (ps_phase)
      PH_MAGIC: begin
        if (tag_byte_done(b)) begin
          if (ps_tag != TAG_MAGIC) begin
            ps_phase = PH_DONE;
            res.kind = KIND_BAD_MAGIC;
            return 1'b1;
          end
          ps_phase = PH_TAG;
        end
      end
      PH_TAG: begin
        if (tag_byte_done(b)) ps_phase = PH_KIND;
      end
      PH_KIND: begin
        ps_kind = b;
        ps_phase = PH_LEN;
      end
      PH_LEN: begin
        if (word_byte_done(b)) begin
          if (ps_kind == FIELD_KIND_DATA && ps_word != 0) begin
            ps_left = ps_word;
            ps_capture = (ps_tag == TAG_KEY && ps_word == KEY_LEN);
            ps_phase = PH_DATA;
          end else begin
            return field_done(res);
          end
        end
      end
      PH_DATA: begin
        idx = KEY_LEN - ps_left;
        cap = ps_capture;
        ps_left = ps_left - 32'd1;
        if (ps_left == 0 && cap) begin
          ps_key_seen = 1'b1;
          ps_capture = 1'b0;
        end
        if (cap) begin
          res.kind = KIND_KEY;
          res.byte_value = b;
          res.byte_index = idx;
          res.key_present = ps_key_seen;
          if (ps_left == 0) ps_phase = PH_TAG;
          return 1'b1;
        end
        if (ps_left == 0) return field_done(res);
      end
      PH_COUNT: begin
        if (word_byte_done(b)) begin
          ps_entries = ps_word;
          ps_entry_idx = '0;
          if (ps_entries == 0) begin
            ps_phase = PH_DONE;
            res.kind = KIND_DIR_END;
            res.position = ps_pos;
            res.key_present = ps_key_seen;
            return 1'b1;
          end
          ps_phase = PH_NAMELEN;
        end
      end
      PH_NAMELEN: begin
        if (word_byte_done(b)) begin
          ps_tag = ps_word;
          ps_left = ps_word;
          ps_phase = (ps_word == 0) ? PH_FIELDS : PH_NAME;
        end
      end
      PH_NAME: begin
        res.kind = KIND_NAME;
        res.byte_value = b;
        res.byte_index = ps_tag - ps_left;
        res.entry_number = ps_entry_idx;
        res.key_present = ps_key_seen;
        ps_left = ps_left - 32'd1;
        if (ps_left == 0) ps_phase = PH_FIELDS;
        return 1'b1;
      end
      PH_FIELDS: begin
        if (word_byte_done(b)) begin
          if (ps_left < 5) ps_fields[ps_left[2:0]] = ps_word;
          ps_left = ps_left + 32'd1;
          if (ps_left >= 5) begin
            ps_left = '0;
            res.kind = KIND_RECORD;
            res.entry_number = ps_entry_idx;
            res.resource_type = ps_fields[0];
            res.size_out = ps_fields[1];
            res.rel_offset = ps_fields[2];
            res.size_in = ps_fields[3];
            res.encrypted = ps_fields[4][0];
            res.name_length = ps_tag;
            res.key_present = ps_key_seen;
            ps_entry_idx = ps_entry_idx + 32'd1;
            ps_phase = (ps_entry_idx == ps_entries) ? PH_PENDING : PH_NAMELEN;
            return 1'b1;
          end
        end
      end
      PH_PENDING: begin
        ps_phase = PH_DONE;
        res.kind = KIND_DIR_END;
        res.entry_number = ps_entries;
        res.position = prev_pos;
        res.key_present = ps_key_seen;
        return 1'b1;
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report_error(input string what);
    error_count++;
    if (error_count <= 40) $display("ERROR at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s is %0h, predicted %0h", name, got, want));
    end
  endtask

  task automatic put_tag(input logic [31:0] tag);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(tag[8*i +: 8]);
  endtask

  task automatic put_dword(input logic [31:0] word);
    for (int i = 0; i < 4; i++) file_bytes.push_back(word[8*i +: 8]);
  endtask

  task automatic put_random_bytes(input int count);
    repeat (count) file_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_field(input logic [31:0] tag, input logic [7:0] kind,
                           input logic [31:0] len);
    put_tag(tag);
    file_bytes.push_back(kind);
    put_dword(len);
    if (kind == FIELD_KIND_DATA) put_random_bytes(int'(len));
  endtask

  task automatic put_entry(input int name_len, input logic [31:0] res_type,
                           input logic [31:0] out_size, input logic [31:0] offset,
                           input logic [31:0] in_size, input logic [31:0] flags);
    put_dword(name_len);
    put_random_bytes(name_len);
    put_dword(res_type);
    put_dword(out_size);
    put_dword(offset);
    put_dword(in_size);
    put_dword(flags);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic start);
    in_item_t  item;
    out_item_t res;
    item.data_byte = b;
    item.file_start = start;
    while ($urandom_range(99) < source_idle_pct) begin
      archive_if.valid <= 1'b0;
      @(negedge clk);
    end
    archive_if.valid <= 1'b1;
    archive_if.data <= item;
    @(posedge clk);
    while (!archive_if.ready) @(posedge clk);
    if (parse_byte(item, res)) directory_reports.push_back(res);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file(input bit with_start);
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], with_start && i == 0);
    end
    file_bytes.delete();
  endtask

  task automatic test_file_without_start();
    put_tag(TAG_MAGIC);
    put_field(TAG_END, 8'h00, 32'hFFFF_FFFF);
    put_dword(32'd0);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    send_file(1'b0);
  endtask

  task automatic test_bad_magic();
    put_tag(32'h4B464E43);
    put_tag(TAG_MAGIC);
    send_file(1'b1);
  endtask

  task automatic test_header_fields();
    put_tag(TAG_MAGIC);
    put_tag(TAG_KEY);
    file_bytes.push_back(FIELD_KIND_DATA);
    put_dword(KEY_LEN);
    for (int i = 0; i < 16; i++) file_bytes.push_back(8'(i * 17));
    put_field(TAG_KEY, FIELD_KIND_DATA, KEY_LEN);
    put_field(TAG_KEY, FIELD_KIND_DATA, 32'd3);
    put_field(TAG_KEY, 8'h01, KEY_LEN);
    put_field(32'h0000_0000, FIELD_KIND_DATA, 32'd0);
    put_field(32'hFFFF_FFFF, 8'hFF, 32'h8000_0001);
    put_field(TAG_END, FIELD_KIND_DATA, 32'd2);
    put_dword(32'd2);
    put_entry(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    put_entry(0, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFE);
    put_random_bytes(3);
    send_file(1'b1);
  endtask

  task automatic test_lost_directory_end();
    put_tag(TAG_MAGIC);
    put_field(TAG_END, 8'h00, 32'd0);
    put_dword(32'd1);
    put_entry(1, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_file(1'b1);
    put_tag(TAG_MAGIC);
    put_field(TAG_END, 8'h00, 32'd0);
    put_dword(32'd0);
    send_file(1'b1);
  endtask

  task automatic test_random_files();
    int          base;
    int          mode;
    int          cut;
    logic [7:0]  kind;
    logic [31:0] tag;
    logic [31:0] len;
    base = bytes_sent;
    while (bytes_sent - base < RANDOM_BYTES) begin
      if (bytes_sent - base >= 300 && bytes_sent - base < 450) begin
        source_idle_pct = 0;
        sink_stall_pct = 0;
      end else begin
        source_idle_pct = 27;
        sink_stall_pct = 27;
      end
      mode = $urandom_range(99);
      if (mode < 6) begin
        put_tag($urandom);
        put_random_bytes($urandom_range(6));
      end else if (mode < 14) begin
        put_tag(TAG_MAGIC);
        put_random_bytes($urandom_range(40, 1));
      end else begin
        put_tag(TAG_MAGIC);
        repeat ($urandom_range(3)) begin
          case ($urandom_range(3))
            0: begin
              tag = TAG_KEY;
              kind = FIELD_KIND_DATA;
              len = KEY_LEN;
            end
            1: begin
              tag = TAG_KEY;
              kind = 8'($urandom_range(3));
              len = (kind == FIELD_KIND_DATA) ? 32'($urandom_range(20)) : $urandom;
            end
            default: begin
              tag = $urandom;
              kind = $urandom_range(1) ? FIELD_KIND_DATA : 8'($urandom_range(255));
              len = (kind == FIELD_KIND_DATA) ? 32'($urandom_range(6)) : $urandom;
            end
          endcase
          put_field(tag, kind, len);
        end
        kind = ($urandom_range(3) == 0) ? FIELD_KIND_DATA : 8'($urandom_range(255));
        len = (kind == FIELD_KIND_DATA) ? 32'($urandom_range(3)) : $urandom;
        put_field(TAG_END, kind, len);
        len = $urandom_range(4);
        put_dword(len);
        repeat (len) put_entry($urandom_range(5), $urandom, $urandom, $urandom, $urandom,
                               $urandom);
        put_random_bytes($urandom_range(3));
        if (mode >= 86) begin
          cut = $urandom_range(file_bytes.size() - 1, 1);
          file_bytes = file_bytes[0:cut-1];
        end
      end
      send_file(1'b1);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    report_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      report_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && report_if.valid && report_if.ready) begin
      got = report_if.data;
      if (directory_reports.size() == 0) begin
        report_error($sformatf("unpredicted report of kind %0d", got.kind));
      end else begin
        want = directory_reports.pop_front();
        check_field("kind", 32'(got.kind), 32'(want.kind));
        check_field("byte_value", 32'(got.byte_value), 32'(want.byte_value));
        check_field("byte_index", got.byte_index, want.byte_index);
        check_field("entry_number", got.entry_number, want.entry_number);
        check_field("resource_type", got.resource_type, want.resource_type);
        check_field("size_out", got.size_out, want.size_out);
        check_field("rel_offset", got.rel_offset, want.rel_offset);
        check_field("size_in", got.size_in, want.size_in);
        check_field("encrypted", 32'(got.encrypted), 32'(want.encrypted));
        check_field("name_length", got.name_length, want.name_length);
        check_field("position", got.position, want.position);
        check_field("key_present", 32'(got.key_present), 32'(want.key_present));
      end
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((archive_if.valid && archive_if.ready) || (report_if.valid && report_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    archive_if.valid = 1'b0;
    archive_if.data = '0;
    clear_parse_state();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_file_without_start();
    test_bad_magic();
    test_header_fields();
    test_lost_directory_end();
    test_random_files();
    archive_if.valid <= 1'b0;
    while (directory_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
